// File: design/svss_pkg.sv
// ----------------------------------------------------------------------------
// svss_pkg
// Shared types and constant tables for the serial value seven-segment scanner.
// ----------------------------------------------------------------------------
package svss_pkg;

	localparam int unsigned DigitCountDefault = 5;
	localparam int unsigned DigitMax          = 5;
	localparam int unsigned PosW              = 3;
	localparam int unsigned ValueW            = 16;
	localparam int unsigned RecipW            = 17;
	localparam int unsigned ShiftW            = 5;
	localparam int unsigned ProdW             = ValueW + RecipW;
	localparam int unsigned TensW             = 13;

	// input kinds
	localparam logic KindByte = 1'b0;
	localparam logic KindTick = 1'b1;

	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		logic [7:0] digit_select;
		logic [6:0] segments;
	} frame_t;

	typedef logic [6:0] seg_t;
	typedef logic [7:0] sel_t;
	typedef logic [RecipW-1:0] recip_t;
	typedef logic [ShiftW-1:0] shift_t;

	localparam seg_t SegOfDigit [10] = '{
		7'h3f, 7'h06, 7'h5b, 7'h4f, 7'h66, 7'h6d, 7'h7d, 7'h07, 7'h7f, 7'h6f
	};

	localparam sel_t SelOfPos [DigitMax] = '{8'hDF, 8'hEF, 8'hF7, 8'hFB, 8'hFD};

	// divide by 1, 10, 100, 1000, 10000 as multiply and shift, exact for 16-bit values
	localparam recip_t RecipOfPos [DigitMax] = '{
		17'd65536, 17'd104858, 17'd83887, 17'd67109, 17'd107375
	};
	localparam shift_t ShiftOfPos [DigitMax] = '{
		5'd16, 5'd20, 5'd23, 5'd26, 5'd30
	};

	localparam recip_t DivTenRecip = 17'd104858;
	localparam shift_t DivTenShift = 5'd20;

endpackage

// File: design/serial_value_seven_segment_scanner.sv
// ----------------------------------------------------------------------------
// serial_value_seven_segment_scanner
// Builds a 16-bit value from received bytes and returns one display frame
// (digit select and segment pattern) for each scan tick.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid / item_stall / item): kind 0 carries a received
//   byte that shifts into the low byte of the shown value, kind 1 is a scan
//   tick. Only ticks produce a frame on the frame channel
//   (frame_valid / frame_stall / frame).
//   A tick's frame passes through the snapshot register, which loads at the
//   edge that takes the tick, then the quotient register, then the frame
//   register. One item is taken every cycle while item_stall is low; the
//   value and scan position update at the edge that takes the transaction,
//   so a tick sees every byte taken before it.
//   Digit extraction uses one constant-reciprocal multiplier per stage: value
//   divided by the digit weight, then the quotient modulo ten.
//   Reset clears the value, the scan position and all stage valids.
//   While a frame waits and frame_stall is high the whole pipeline holds and
//   item_stall is raised; nothing is dropped.
// ----------------------------------------------------------------------------
module serial_value_seven_segment_scanner #(
	parameter int unsigned DIGIT_COUNT = svss_pkg::DigitCountDefault
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_stall,
	input  svss_pkg::item_t item,
	output logic            frame_valid,
	input  logic            frame_stall,
	output svss_pkg::frame_t frame
);
	import svss_pkg::*;

	localparam logic [PosW-1:0] LastPos = PosW'(DIGIT_COUNT - 1);

	logic [ValueW-1:0] value_q;
	logic [PosW-1:0]   scan_q;
	logic              advance;
	logic              take;
	logic [PosW-1:0]   cur_pos;
	logic [PosW-1:0]   next_pos;

	logic              s1_vld;
	logic [ValueW-1:0] value_s1;
	logic [PosW-1:0]   pos_s1;
	logic              s2_vld;
	logic [ValueW-1:0] quot_s2;
	logic [PosW-1:0]   pos_s2;

	logic [ProdW-1:0]  prod1;
	logic [ValueW-1:0] quot1;
	logic [ProdW-1:0]  prod2;
	logic [TensW-1:0]  tens;
	logic [ValueW-1:0] tens_x10;
	logic [3:0]        digit;

	logic   frame_vld_q;
	frame_t frame_q;

	assign advance    = !(frame_vld_q && frame_stall);
	assign item_stall = !advance;
	assign take       = item_valid && advance;

	// out-of-range position counts as position zero
	assign cur_pos  = (scan_q <= LastPos) ? scan_q : '0;
	assign next_pos = (cur_pos == LastPos) ? '0 : cur_pos + PosW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= '0;
			scan_q  <= '0;
		end else if (take) begin
			if (item.kind == KindByte) begin
				value_q <= {value_q[7:0], item.data_byte};
			end else begin
				scan_q <= next_pos;
			end
		end
	end

	// stage 1: snapshot of value and position for a tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld <= 1'b0;
		end else if (advance) begin
			s1_vld <= take && (item.kind == KindTick);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			value_s1 <= value_q;
			pos_s1   <= cur_pos;
		end
	end

	// value / weight
	assign prod1 = ProdW'(value_s1) * ProdW'(RecipOfPos[pos_s1]);
	assign quot1 = ValueW'(prod1 >> ShiftOfPos[pos_s1]);

	// stage 2: quotient
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_vld <= 1'b0;
		end else if (advance) begin
			s2_vld <= s1_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			quot_s2 <= quot1;
			pos_s2  <= pos_s1;
		end
	end

	// quotient mod 10
	assign prod2    = ProdW'(quot_s2) * ProdW'(DivTenRecip);
	assign tens     = TensW'(prod2 >> DivTenShift);
	assign tens_x10 = ValueW'({tens, 3'b000}) + ValueW'({tens, 1'b0});
	assign digit    = 4'(quot_s2 - tens_x10);

	// frame register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_vld_q <= 1'b0;
		end else if (advance) begin
			frame_vld_q <= s2_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			frame_q.digit_select <= SelOfPos[pos_s2];
			frame_q.segments     <= SegOfDigit[digit];
		end
	end

	assign frame_valid = frame_vld_q;
	assign frame       = frame_q;

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		scan_q <= LastPos)
		else $error("scan position out of range");

	a_digit_decimal: assert property (@(posedge clk) disable iff (!arst_n)
		s2_vld |-> digit < 4'd10)
		else $error("extracted digit is not decimal");

	a_byte_shift: assert property (@(posedge clk) disable iff (!arst_n)
		(take && item.kind == KindByte) |=>
		(value_q[7:0] == $past(item.data_byte) && value_q[15:8] == $past(value_q[7:0])))
		else $error("byte transaction did not shift into value");

	a_tick_reaches_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(take && item.kind == KindTick) |=> s1_vld)
		else $error("tick transaction lost before stage 1");

	a_pipe_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_vld && advance) |=> frame_vld_q)
		else $error("stage 2 result lost before frame register");

endmodule
